// ===== src/ascf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascf_pkg
// Types and codes shared by the condition, shifter and flag slice.
// ----------------------------------------------------------------------------
package ascf_pkg;

	localparam int WORD_BITS  = 32;
	localparam int SHAMT_BITS = 5;

	// flag nibble bit positions
	localparam int FLAG_N_BIT = 3;
	localparam int FLAG_Z_BIT = 2;
	localparam int FLAG_C_BIT = 1;
	localparam int FLAG_V_BIT = 0;

	// condition codes
	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

	// shift kinds
	localparam logic [1:0] SHIFT_LSL = 2'd0;
	localparam logic [1:0] SHIFT_LSR = 2'd1;
	localparam logic [1:0] SHIFT_ASR = 2'd2;
	localparam logic [1:0] SHIFT_ROR = 2'd3;

	// flag update modes
	localparam logic [1:0] FMODE_KEEP = 2'd0;
	localparam logic [1:0] FMODE_DP   = 2'd1;
	localparam logic [1:0] FMODE_MUL  = 2'd2;

	typedef struct packed {
		logic [3:0]            flags;
		logic [3:0]            cond;
		logic [WORD_BITS-1:0]  operand;
		logic [1:0]            kind;
		logic [SHAMT_BITS-1:0] amount;
		logic [WORD_BITS-1:0]  alu;
		logic                  carry;
		logic [1:0]            fmode;
	} item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] value;
		logic                 carry;
	} shift_res_t;

	typedef struct packed {
		logic                 passed;
		shift_res_t           shift;
		logic [3:0]           flags;
	} result_t;

endpackage
`default_nettype wire

// ===== src/ascf_cond.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascf_cond
// Condition code check against the current NZCV flags.
// ----------------------------------------------------------------------------
module ascf_cond import ascf_pkg::*; (
	input  wire logic [3:0] flags,
	input  wire logic [3:0] cond,
	output logic            passed
);

	logic n_eq_v;
	logic z;

	assign z      = flags[FLAG_Z_BIT];
	assign n_eq_v = (flags[FLAG_N_BIT] == flags[FLAG_V_BIT]);

	always_comb begin
		case (cond)
			COND_EQ: passed = z;
			COND_NE: passed = ~z;
			COND_GE: passed = n_eq_v;
			COND_LT: passed = ~n_eq_v;
			COND_GT: passed = ~z & n_eq_v;
			COND_LE: passed = z | ~n_eq_v;
			COND_AL: passed = 1'b1;
			default: passed = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/ascf_shift.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascf_shift
// Barrel shifter (LSL, LSR, ASR, ROR) with shifter carry out.
// ----------------------------------------------------------------------------
module ascf_shift import ascf_pkg::*; (
	input  wire logic [WORD_BITS-1:0]  operand,
	input  wire logic [1:0]            kind,
	input  wire logic [SHAMT_BITS-1:0] amount,
	input  wire logic                  c_flag,
	output shift_res_t                 res
);

	logic [WORD_BITS-1:0]   fill;
	logic [2*WORD_BITS-1:0] right_ext;
	logic [WORD_BITS-1:0]   right_val;
	logic [WORD_BITS-1:0]   left_val;
	logic [SHAMT_BITS-1:0]  right_idx;
	logic [SHAMT_BITS-1:0]  left_idx;

	// upper half supplies the bits that enter from the top
	always_comb begin
		case (kind)
			SHIFT_ASR: fill = {WORD_BITS{operand[WORD_BITS-1]}};
			SHIFT_ROR: fill = operand;
			default:   fill = '0;
		endcase
	end

	assign right_ext = {fill, operand} >> amount;
	assign right_val = right_ext[WORD_BITS-1:0];
	assign left_val  = operand << amount;
	assign right_idx = amount - SHAMT_BITS'(1);
	// wraps to word width minus amount for a non-zero amount
	assign left_idx  = SHAMT_BITS'(0) - amount;

	always_comb begin
		if (amount == '0) begin
			res.value = operand;
			res.carry = c_flag;
		end else if (kind == SHIFT_LSL) begin
			res.value = left_val;
			res.carry = operand[left_idx];
		end else begin
			res.value = right_val;
			res.carry = operand[right_idx];
		end
	end

endmodule
`default_nettype wire

// ===== src/ascf_flags.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascf_flags
// New NZCV nibble from an ALU result and carry, by flag update mode.
// ----------------------------------------------------------------------------
module ascf_flags import ascf_pkg::*; (
	input  wire logic [3:0]           flags,
	input  wire logic [WORD_BITS-1:0] alu,
	input  wire logic                 carry,
	input  wire logic [1:0]           fmode,
	output logic [3:0]                flags_new
);

	logic n;
	logic z;

	assign n = alu[WORD_BITS-1];
	assign z = (alu == '0);

	always_comb begin
		case (fmode)
			FMODE_DP:  flags_new = {n, z, carry, flags[FLAG_V_BIT]};
			FMODE_MUL: flags_new = {n, z, flags[FLAG_C_BIT], flags[FLAG_V_BIT]};
			default:   flags_new = flags;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/arm_shift_condition_flags_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_shift_condition_flags_unit_core
// Condition check, barrel shifter and flag update slice of an execute stage.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one beat per item: flags, condition
// code, shift operand with kind and amount, ALU result, carry and flag mode.
// Output channel (out_valid/out_ready) gives one beat per item: condition
// pass, shifted value, shifter carry and updated flags.
// An accepted beat lands in the input register (_s1); the condition, shifter
// and flag logic sit between it and the result register (_s2). A beat passes
// through the input register and then the result register before out_valid
// rises; while out_ready stays high, throughput is one item per cycle, set by
// the single register pair with no iteration.
// When the receiver stalls, the result register holds its beat and the input
// register fills; in_ready then drops until out_ready returns. Up to two
// items are held at once.
// Reset clears both valid flags; the block is ready to take items as soon as
// reset is released.
// ----------------------------------------------------------------------------
module arm_shift_condition_flags_unit_core import ascf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [3:0]            flags_in,
	input  wire logic [3:0]            cond_code,
	input  wire logic [WORD_BITS-1:0]  operand_value,
	input  wire logic [1:0]            shift_kind,
	input  wire logic [SHAMT_BITS-1:0] shift_amount,
	input  wire logic [WORD_BITS-1:0]  alu_result,
	input  wire logic                  carry_in,
	input  wire logic [1:0]            flag_mode,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       cond_passed,
	output logic [WORD_BITS-1:0]       shift_result,
	output logic                       shift_carry_out,
	output logic [3:0]                 flags_out
);

	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	result_t    res_comb;
	logic       pass_c;
	shift_res_t shift_c;
	logic [3:0] flags_c;
	logic       s2_free;
	logic       advance;

	assign s2_free  = ~valid_s2 | out_ready;
	assign advance  = valid_s1 & s2_free;
	assign in_ready = ~valid_s1 | s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.flags   <= flags_in;
			item_s1.cond    <= cond_code;
			item_s1.operand <= operand_value;
			item_s1.kind    <= shift_kind;
			item_s1.amount  <= shift_amount;
			item_s1.alu     <= alu_result;
			item_s1.carry   <= carry_in;
			item_s1.fmode   <= flag_mode;
		end
	end

	ascf_cond u_cond (
		.flags  (item_s1.flags),
		.cond   (item_s1.cond),
		.passed (pass_c)
	);

	ascf_shift u_shift (
		.operand (item_s1.operand),
		.kind    (item_s1.kind),
		.amount  (item_s1.amount),
		.c_flag  (item_s1.flags[FLAG_C_BIT]),
		.res     (shift_c)
	);

	ascf_flags u_flags (
		.flags     (item_s1.flags),
		.alu       (item_s1.alu),
		.carry     (item_s1.carry),
		.fmode     (item_s1.fmode),
		.flags_new (flags_c)
	);

	assign res_comb = {pass_c, shift_c, flags_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid       = valid_s2;
	assign cond_passed     = res_s2.passed;
	assign shift_result    = res_s2.shift.value;
	assign shift_carry_out = res_s2.shift.carry;
	assign flags_out       = res_s2.flags;

endmodule
`default_nettype wire

// ===== src/ascf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascf_checker
// Port-level checks on the slice: latency bound, readiness and output hold.
// ----------------------------------------------------------------------------
module ascf_checker import ascf_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  cond_passed,
	input wire logic [WORD_BITS-1:0]  shift_result,
	input wire logic                  shift_carry_out,
	input wire logic [3:0]            flags_out
);

	// out_valid must be high once an accepted beat has had time to pass the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted beat did not reach the output in two cycles");

	// with nothing waiting at the output the input side must be open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output register empty");

	// a full pipe with a stalled receiver cannot take more
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && $past(out_valid && !out_ready)
		&& $past(in_valid && in_ready) |-> !in_ready)
		else $error("input taken while both stages held");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shift_result)
		&& $stable(flags_out) && $stable(cond_passed) && $stable(shift_carry_out))
		else $error("output beat changed while stalled");

endmodule

bind arm_shift_condition_flags_unit_core ascf_checker u_ascf_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the condition, barrel shifter and flag slice.
// A queue of items (a directed opening, then about 1200 random ones) feeds a
// clocked driver. A clocked monitor compares every output beat with the oldest
// prediction. Both sides idle at random, the receiver holds off once for a
// long stretch, and the sender waits for the pipeline to empty twice.
// ----------------------------------------------------------------------------
module tb import ascf_pkg::*;;

	localparam int N_RANDOM   = 1200;
	localparam int PAUSE_AT   = 600;
	localparam int HOLD_AT    = 350;
	localparam int HOLD_LEN   = 80;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORT = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [3:0]            flags_in = '0;
	logic [3:0]            cond_code = '0;
	logic [WORD_BITS-1:0]  operand_value = '0;
	logic [1:0]            shift_kind = '0;
	logic [SHAMT_BITS-1:0] shift_amount = '0;
	logic [WORD_BITS-1:0]  alu_result = '0;
	logic                  carry_in = 1'b0;
	logic [1:0]            flag_mode = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  cond_passed;
	logic [WORD_BITS-1:0]  shift_result;
	logic                  shift_carry_out;
	logic [3:0]            flags_out;

	item_t   queued_items[$];
	result_t awaited_results[$];
	item_t   cur_item;

	int n_items = 0;
	int n_directed = 0;
	int n_sent = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_cond_pass = 0;
	int n_errors = 0;
	int tx_gap = 0;
	bit tx_burst = 1'b0;
	int rx_stall = 0;
	int rx_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;

	arm_shift_condition_flags_unit_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.flags_in        (flags_in),
		.cond_code       (cond_code),
		.operand_value   (operand_value),
		.shift_kind      (shift_kind),
		.shift_amount    (shift_amount),
		.alu_result      (alu_result),
		.carry_in        (carry_in),
		.flag_mode       (flag_mode),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cond_passed     (cond_passed),
		.shift_result    (shift_result),
		.shift_carry_out (shift_carry_out),
		.flags_out       (flags_out)
	);

	always #1 clk = ~clk;

	// condition test, barrel shift and flag update for one item
	function automatic result_t compute_slice_result(item_t it);
		result_t              r;
		logic                 n;
		logic                 z;
		logic                 v;
		logic                 nv_eq;
		logic [WORD_BITS-1:0] val;
		int                   amt;
		n = it.flags[FLAG_N_BIT];
		z = it.flags[FLAG_Z_BIT];
		v = it.flags[FLAG_V_BIT];
		nv_eq = (n == v);
		case (it.cond)
			COND_EQ: r.passed = z;
			COND_NE: r.passed = ~z;
			COND_GE: r.passed = nv_eq;
			COND_LT: r.passed = ~nv_eq;
			COND_GT: r.passed = ~z & nv_eq;
			COND_LE: r.passed = z | ~nv_eq;
			COND_AL: r.passed = 1'b1;
			default: r.passed = 1'b0;
		endcase
		val = it.operand;
		amt = it.amount;
		// zero amount passes the word through and the carry comes from C
		if (amt == 0) begin
			r.shift.value = val;
			r.shift.carry = it.flags[FLAG_C_BIT];
		end else begin
			case (it.kind)
				SHIFT_LSL: begin
					r.shift.value = val << amt;
					r.shift.carry = val[WORD_BITS-amt];
				end
				SHIFT_LSR: begin
					r.shift.value = val >> amt;
					r.shift.carry = val[amt-1];
				end
				SHIFT_ASR: begin
					r.shift.value = $signed(val) >>> amt;
					r.shift.carry = val[amt-1];
				end
				default: begin
					r.shift.value = (val >> amt) | (val << (WORD_BITS - amt));
					r.shift.carry = val[amt-1];
				end
			endcase
		end
		r.flags = it.flags;
		case (it.fmode)
			FMODE_DP: begin
				r.flags[FLAG_N_BIT] = it.alu[WORD_BITS-1];
				r.flags[FLAG_Z_BIT] = (it.alu == '0);
				r.flags[FLAG_C_BIT] = it.carry;
			end
			FMODE_MUL: begin
				r.flags[FLAG_N_BIT] = it.alu[WORD_BITS-1];
				r.flags[FLAG_Z_BIT] = (it.alu == '0);
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 12)
			return 0;
		else if (roll < 18)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [WORD_BITS-1:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.flags   = 4'($urandom_range(0, 15));
		it.cond    = 4'($urandom_range(0, 15));
		it.operand = random_word();
		it.kind    = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: it.amount = '0;
			1: it.amount = '1;
			default: it.amount = SHAMT_BITS'($urandom_range(0, 31));
		endcase
		it.alu   = random_word();
		it.carry = 1'($urandom_range(0, 1));
		it.fmode = 2'($urandom_range(0, 3));
		return it;
	endfunction

	initial begin
		item_t                it;
		logic [WORD_BITS-1:0] operands[5];
		logic [WORD_BITS-1:0] alus[4];
		logic [4:0]           amounts[6];
		operands = '{32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFE,
			32'hA5A5_A5A5};
		alus = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
		amounts = '{5'd0, 5'd31, 5'd1, 5'd13, 5'd0, 5'd31};
		// opening: every condition code, each shift kind at zero, one and full
		// amounts, every flag mode, extreme operands and results
		for (int i = 0; i < 24; i++) begin
			it.flags   = 4'((i * 5) % 16);
			it.cond    = 4'(i % 16);
			it.operand = operands[i % 5];
			it.kind    = 2'(i % 4);
			it.amount  = amounts[i / 4];
			it.alu     = alus[(i / 2) % 4];
			it.carry   = 1'(i % 2);
			it.fmode   = 2'((i / 3) % 4);
			queued_items.push_back(it);
		end
		n_directed = queued_items.size();
		for (int i = 0; i < N_RANDOM; i++)
			queued_items.push_back(random_item());
		n_items = queued_items.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_items || awaited_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("%0d results checked over all condition codes, shift kinds and flag modes",
			n_checked);
		$display("%0d conditions passed, %0d mismatches", n_cond_pass, n_errors);
		if (n_errors == 0 && awaited_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// sender: holds each beat until taken, waits for an empty pipe twice
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_results.push_back(compute_slice_result(cur_item));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (queued_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if ((n_sent == n_directed || n_sent == PAUSE_AT)
						&& awaited_results.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					cur_item = queued_items.pop_front();
					n_sent++;
					flags_in      <= cur_item.flags;
					cond_code     <= cur_item.cond;
					operand_value <= cur_item.operand;
					shift_kind    <= cur_item.kind;
					shift_amount  <= cur_item.amount;
					alu_result    <= cur_item.alu;
					carry_in      <= cur_item.carry;
					flag_mode     <= cur_item.fmode;
					in_valid      <= 1'b1;
					// every third block of a hundred beats goes back to back
					tx_burst = ((n_sent / 100) % 3) == 2;
					tx_gap = tx_burst ? 0 : pick_gap();
				end
			end
		end
	end

	// receiver: checks each beat, stalls at random, one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycles++;
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORT)
						$display("unexpected result beat: pass=%0b value=%08h carry=%0b flags=%04b",
							cond_passed, shift_result, shift_carry_out, flags_out);
				end else begin
					result_t want;
					want = awaited_results.pop_front();
					n_checked++;
					if (cond_passed)
						n_cond_pass++;
					if (cond_passed !== want.passed || shift_result !== want.shift.value
							|| shift_carry_out !== want.shift.carry
							|| flags_out !== want.flags) begin
						n_errors++;
						if (n_errors <= MAX_REPORT)
							$display("mismatch on result %0d: want %0b %08h %0b %04b, got %0b %08h %0b %04b",
								n_checked, want.passed, want.shift.value, want.shift.carry,
								want.flags, cond_passed, shift_result, shift_carry_out,
								flags_out);
					end
				end
			end
			if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ((rx_cycles % 512) >= 128)
					rx_stall = pick_gap();
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles, %0d of %0d items accepted",
					idle_cycles, n_accepted, n_items);
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule
